/* rtl/tile_linear_reorder_address_macros.svh */
// Assertion macros shared by the tile/linear reorder address generator.
`ifndef TILE_LINEAR_REORDER_ADDRESS_MACROS_SVH
`define TILE_LINEAR_REORDER_ADDRESS_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define TLRA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TLRA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tlra_pkg.sv */
// Shared types, constants and helpers of the tile/linear reorder address generator.
package tlra_pkg;

  localparam int PIX_W        = 32;
  localparam int DEST_W       = 28;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 64;
  localparam int SIZE_REG_W   = 11;
  localparam int COUNT_REG_W  = 5;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_INDEX_W  = 3;
  localparam int CLAMP_W      = 13;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TILES_ACROSS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TILES_DOWN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION    = 3'd4;

  // Direction codes
  localparam logic DIR_TILE_TO_ROW = 1'b0;
  localparam logic DIR_ROW_TO_TILE = 1'b1;

  typedef struct packed {
    logic [SIZE_REG_W-1:0]  tile_width;
    logic [SIZE_REG_W-1:0]  tile_height;
    logic [COUNT_REG_W-1:0] tiles_across;
    logic [COUNT_REG_W-1:0] tiles_down;
    logic                   direction;
  } cfg_regs_t;

  // Zero acts as one, values above the limit saturate to it.
  function automatic logic [CLAMP_W-1:0] clamp_reg(input logic [SIZE_REG_W-1:0] v,
                                                    input logic [CLAMP_W-1:0] hi);
    logic [CLAMP_W-1:0] ext;
    ext = CLAMP_W'(v);
    if (ext == '0) return CLAMP_W'(1);
    if (ext > hi) return hi;
    return ext;
  endfunction

endpackage

/* rtl/tlra_queue.sv */
// Small register queue between the counter front end and the address back end.
module tlra_queue
  import tlra_pkg::*;
#(
  parameter int WIDTH = 73,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full      = (count == NW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

`include "tile_linear_reorder_address_macros.svh"

  `TLRA_ASSERT(a_no_push_when_full, clk, rst, !(push && full), "push into full queue")

endmodule

/* rtl/tlra_front.sv */
// Front end: accepts pixels, applies restart, steps the tile and pixel counters.
module tlra_front
  import tlra_pkg::*;
#(
  parameter int MAX_TILE_SIZE = 1024,
  parameter int MAX_TILES     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_regs_t             cfg,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [PIX_W + 2*((MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1)
                + 2*((MAX_TILES > 1) ? $clog2(MAX_TILES) : 1):0] q_data
);

  localparam int CW   = (MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1;
  localparam int TCW  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int SZ_W = $clog2(MAX_TILE_SIZE + 1);
  localparam int NT_W = $clog2(MAX_TILES + 1);
  localparam int LW   = ((CW > SZ_W) ? CW : SZ_W) + 1;
  localparam int LTW  = ((TCW > NT_W) ? TCW : NT_W) + 1;

  logic [CW-1:0]   col, row;
  logic [TCW-1:0]  tcol, trow;
  logic [CW-1:0]   col_eff, row_eff, col_next, row_next;
  logic [TCW-1:0]  tcol_eff, trow_eff, tcol_next, trow_next;
  logic [SZ_W-1:0] tw, th;
  logic [NT_W-1:0] ta, td;
  logic            col_end, row_end, tcol_end, trow_end;
  logic            last_flag;
  logic            accept;

  // Effective sizes from the raw registers
  assign tw = SZ_W'(clamp_reg(cfg.tile_width, CLAMP_W'(MAX_TILE_SIZE)));
  assign th = SZ_W'(clamp_reg(cfg.tile_height, CLAMP_W'(MAX_TILE_SIZE)));
  assign ta = NT_W'(clamp_reg(SIZE_REG_W'(cfg.tiles_across), CLAMP_W'(MAX_TILES)));
  assign td = NT_W'(clamp_reg(SIZE_REG_W'(cfg.tiles_down), CLAMP_W'(MAX_TILES)));

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;
  assign q_push   = accept;

  // Restart clears the counters before this pixel is mapped
  assign col_eff  = s_tuser ? '0 : col;
  assign row_eff  = s_tuser ? '0 : row;
  assign tcol_eff = s_tuser ? '0 : tcol;
  assign trow_eff = s_tuser ? '0 : trow;

  assign col_end  = (LW'(col_eff) + LW'(1)) >= LW'(tw);
  assign row_end  = (LW'(row_eff) + LW'(1)) >= LW'(th);
  assign tcol_end = (LTW'(tcol_eff) + LTW'(1)) >= LTW'(ta);
  assign trow_end = (LTW'(trow_eff) + LTW'(1)) >= LTW'(td);

  assign last_flag = col_end && row_end && tcol_end && trow_end;

  assign q_data = {last_flag, trow_eff, tcol_eff, row_eff, col_eff, s_tdata[PIX_W-1:0]};

  // Step the counters in the order of the source layout
  always_comb begin
    col_next  = col_end ? '0 : col_eff + CW'(1);
    row_next  = row_eff;
    tcol_next = tcol_eff;
    trow_next = trow_eff;
    if (cfg.direction == DIR_TILE_TO_ROW) begin
      if (col_end) begin
        row_next = row_end ? '0 : row_eff + CW'(1);
      end
      if (col_end && row_end) begin
        tcol_next = tcol_end ? '0 : tcol_eff + TCW'(1);
      end
      if (col_end && row_end && tcol_end) begin
        trow_next = trow_end ? '0 : trow_eff + TCW'(1);
      end
    end else begin
      if (col_end) begin
        tcol_next = tcol_end ? '0 : tcol_eff + TCW'(1);
      end
      if (col_end && tcol_end) begin
        row_next = row_end ? '0 : row_eff + CW'(1);
      end
      if (col_end && tcol_end && row_end) begin
        trow_next = trow_end ? '0 : trow_eff + TCW'(1);
      end
    end
  end

  // Update counters on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      tcol <= '0;
      trow <= '0;
    end else if (accept) begin
      col  <= col_next;
      row  <= row_next;
      tcol <= tcol_next;
      trow <= trow_next;
    end
  end

`include "tile_linear_reorder_address_macros.svh"

  `TLRA_ASSERT(a_last_wraps_counters, clk, rst, accept && last_flag |=> (col == '0 && row == '0 && tcol == '0 && trow == '0), "counters did not wrap after last pixel")

endmodule

/* rtl/tlra_back.sv */
// Back end: three-stage address pipeline with the output register.
module tlra_back
  import tlra_pkg::*;
#(
  parameter int MAX_TILE_SIZE = 1024,
  parameter int MAX_TILES     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_regs_t              cfg,
  input  logic                   q_valid,
  input  logic [PIX_W + 2*((MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1)
                + 2*((MAX_TILES > 1) ? $clog2(MAX_TILES) : 1):0] q_data,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int CW   = (MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1;
  localparam int TCW  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int SZ_W = $clog2(MAX_TILE_SIZE + 1);
  localparam int NT_W = $clog2(MAX_TILES + 1);
  localparam int AW_W = SZ_W + NT_W;
  localparam int AR_W = 2 * SZ_W;
  localparam int A_W  = TCW + ((SZ_W > NT_W) ? SZ_W : NT_W) + 1;
  localparam int PAD_W = OUT_TDATA_W - PIX_W - DEST_W;

  logic [SZ_W-1:0]   tw, th;
  logic [NT_W-1:0]   ta;
  logic [AW_W-1:0]   atlas_w;
  logic [AR_W-1:0]   tile_area;

  logic [PIX_W-1:0]  q_pix;
  logic [CW-1:0]     q_col, q_row;
  logic [TCW-1:0]    q_tcol, q_trow;
  logic              q_last;

  logic              va, vb, vc;
  logic              rdy_a, rdy_b, rdy_c;
  logic [A_W-1:0]    a_a, a_next;
  logic [DEST_W-1:0] b_a, b_next, c_a, c_next;
  logic [PIX_W-1:0]  pix_a, pix_b, pix_c;
  logic              last_a, last_b, last_c;
  logic [DEST_W-1:0] m_b, s_b, k_sel, dest_c;

  assign tw = SZ_W'(clamp_reg(cfg.tile_width, CLAMP_W'(MAX_TILE_SIZE)));
  assign th = SZ_W'(clamp_reg(cfg.tile_height, CLAMP_W'(MAX_TILE_SIZE)));
  assign ta = NT_W'(clamp_reg(SIZE_REG_W'(cfg.tiles_across), CLAMP_W'(MAX_TILES)));

  // Atlas width, tile area; user must keep config quiet with beats in flight, unenforced
  always_ff @(posedge clk) begin
    atlas_w   <= AW_W'(tw) * AW_W'(ta);
    tile_area <= AR_W'(tw) * AR_W'(th);
  end

  assign {q_last, q_trow, q_tcol, q_row, q_col, q_pix} = q_data;

  // Stall chain from the output register back to the queue
  assign rdy_c = !vc || m_tready;
  assign rdy_b = !vb || rdy_c;
  assign rdy_a = !va || rdy_b;
  assign q_pop = q_valid && rdy_a;

  // Stage A: tile term, in-tile offset and, in tile to row order, the tile column offset
  always_comb begin
    if (cfg.direction == DIR_TILE_TO_ROW) begin
      a_next = A_W'(q_trow) * A_W'(th);
      b_next = DEST_W'(q_row) * DEST_W'(atlas_w) + DEST_W'(q_col);
      c_next = DEST_W'(q_tcol) * DEST_W'(tw);
    end else begin
      a_next = A_W'(q_trow) * A_W'(ta) + A_W'(q_tcol);
      b_next = DEST_W'(q_row) * DEST_W'(tw) + DEST_W'(q_col);
      c_next = '0;
    end
  end

  // Stage B picks the scale of the tile term
  assign k_sel = (cfg.direction == DIR_TILE_TO_ROW) ? DEST_W'(atlas_w) : DEST_W'(tile_area);

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= q_pop;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (rdy_a && q_pop) begin
      a_a    <= a_next;
      b_a    <= b_next;
      c_a    <= c_next;
      pix_a  <= q_pix;
      last_a <= q_last;
    end
    if (rdy_b && va) begin
      m_b    <= DEST_W'(a_a) * k_sel;
      s_b    <= b_a + c_a;
      pix_b  <= pix_a;
      last_b <= last_a;
    end
    if (rdy_c && vb) begin
      dest_c <= m_b + s_b;
      pix_c  <= pix_b;
      last_c <= last_b;
    end
  end

  assign m_tvalid = vc;
  assign m_tdata  = {PAD_W'(0), pix_c, dest_c};
  assign m_tlast  = last_c;

`include "tile_linear_reorder_address_macros.svh"

  `TLRA_ASSERT(a_stage_b_holds, clk, rst, vb && !rdy_b |=> vb && $stable(m_b) && $stable(s_b), "stage B lost data under stall")
  `TLRA_ASSERT_NR(a_reset_empties, clk, rst |=> !va && !vb && !vc, "pipeline not empty after reset")

endmodule

/* rtl/tile_linear_reorder_address.sv */
// Top level of the tile/linear layout reorder address generator.
//
// Pixels enter on the s_* stream, one beat per pixel: s_tdata carries the pixel,
// s_tuser the restart flag that makes the pixel the first of a new atlas. Each
// pixel leaves on the m_* stream with its index in the other layout; m_tlast
// marks the final pixel of the atlas, after which the counters wrap to the start.
// The cfg_* port writes tile width, tile height, tiles across, tiles down and
// direction, one register per write; the user must write only while no beats
// are in flight, which the block does not enforce. Throughput is one pixel per
// clock while m_tready stays high; the counter front end decides each beat's
// position combinationally, and the address back end is a three-stage pipeline
// (two multiply stages and a final add into the output register). An input
// beat is written into the queue, then registered through stages A, B and C. A
// four-entry queue parts the two ends; when m_tready is low the back end holds
// its stages, the queue fills and s_tready then drops.
// Synchronous reset restores the register defaults (256 by 256 pixel tiles,
// 4 by 4 tiles, tile to row order), clears the counters, empties the queue
// and drops m_tvalid.
module tile_linear_reorder_address
  import tlra_pkg::*;
#(
  parameter int MAX_TILE_SIZE = 1024,
  parameter int MAX_TILES     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata: [31:0] pixel
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: [0] restart
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata: [27:0] dest_index, [59:28] pixel_out, [63:60] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int CW          = (MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1;
  localparam int TCW         = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int ENTRY_W     = PIX_W + 2 * CW + 2 * TCW + 1;
  localparam int QUEUE_DEPTH = 4;

  cfg_regs_t          cfg;
  logic               q_push, q_pop, q_full, q_valid;
  logic [ENTRY_W-1:0] q_in, q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width   <= SIZE_REG_W'(256);
      cfg.tile_height  <= SIZE_REG_W'(256);
      cfg.tiles_across <= COUNT_REG_W'(4);
      cfg.tiles_down   <= COUNT_REG_W'(4);
      cfg.direction    <= DIR_TILE_TO_ROW;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TILE_WIDTH:   cfg.tile_width   <= cfg_data[SIZE_REG_W-1:0];
        REG_TILE_HEIGHT:  cfg.tile_height  <= cfg_data[SIZE_REG_W-1:0];
        REG_TILES_ACROSS: cfg.tiles_across <= cfg_data[COUNT_REG_W-1:0];
        REG_TILES_DOWN:   cfg.tiles_down   <= cfg_data[COUNT_REG_W-1:0];
        REG_DIRECTION:    cfg.direction    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlra_front #(
    .MAX_TILE_SIZE(MAX_TILE_SIZE),
    .MAX_TILES    (MAX_TILES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  tlra_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .not_empty(q_valid)
  );

  tlra_back #(
    .MAX_TILE_SIZE(MAX_TILE_SIZE),
    .MAX_TILES    (MAX_TILES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

/* sim/tile_linear_reorder_address_tb.sv */
// Self-checking testbench for the tile/row layout reorder address generator.
module tile_linear_reorder_address_tb;
  import tlra_pkg::*;

  localparam int MAX_TILE_PIX  = 1024;
  localparam int MAX_TILE_CNT  = 16;
  localparam int RANDOM_PIXELS = 1800;
  localparam int CALM_TAIL     = 200;
  localparam int PIPE_DEPTH    = 3;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             restart;
  } pixel_item_t;

  typedef struct {
    logic [DEST_W-1:0] dest;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } mapped_pixel_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  // Register copy kept by the predictor
  logic [SIZE_REG_W-1:0]  reg_tile_w = 11'd256;
  logic [SIZE_REG_W-1:0]  reg_tile_h = 11'd256;
  logic [COUNT_REG_W-1:0] reg_across = 5'd4;
  logic [COUNT_REG_W-1:0] reg_down = 5'd4;
  logic                   reg_dir = DIR_TILE_TO_ROW;

  // Position counters kept by the predictor
  logic [9:0] col_pos = '0;
  logic [9:0] row_pos = '0;
  logic [3:0] tile_x = '0;
  logic [3:0] tile_y = '0;

  pixel_item_t   pixel_q[$];
  mapped_pixel_t mapped_q[$];
  pixel_item_t   next_pix;

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int queued = 0;
  int atlas_ends = 0;
  int phases = 0;
  int rand_pixels = 0;
  int cycle_count = 0;

  tile_linear_reorder_address #(
    .MAX_TILE_SIZE(MAX_TILE_PIX),
    .MAX_TILES(MAX_TILE_CNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Zero acts as one, anything above the limit saturates
  function automatic longint unsigned eff_size(input logic [SIZE_REG_W-1:0] v,
                                               input int top);
    if (v == '0) return 1;
    if (v > top) return 64'(top);
    return 64'(v);
  endfunction

  function automatic bit at_limit(input longint unsigned c, input longint unsigned lim);
    return c + 1 >= lim;
  endfunction

  // Map one accepted pixel to its destination index and step the counters
  task automatic map_pixel(input logic [PIX_W-1:0] pix, input logic restart);
    longint unsigned tw, th, ta, td, aw, base, dest;
    mapped_pixel_t m;
    bit wrapped;
    tw = eff_size(reg_tile_w, MAX_TILE_PIX);
    th = eff_size(reg_tile_h, MAX_TILE_PIX);
    ta = eff_size(SIZE_REG_W'(reg_across), MAX_TILE_CNT);
    td = eff_size(SIZE_REG_W'(reg_down), MAX_TILE_CNT);
    aw = ta * tw;
    if (restart) begin
      col_pos = '0;
      row_pos = '0;
      tile_x = '0;
      tile_y = '0;
    end
    if (reg_dir == DIR_TILE_TO_ROW) begin
      base = tile_y * th * aw + tile_x * tw;
      dest = base + row_pos * aw + col_pos;
    end else begin
      base = (tile_y * ta + tile_x) * (tw * th);
      dest = base + row_pos * tw + col_pos;
    end
    m.dest = dest[DEST_W-1:0];
    m.pixel = pix;
    m.last = at_limit(col_pos, tw) && at_limit(row_pos, th) &&
             at_limit(tile_x, ta) && at_limit(tile_y, td);
    mapped_q.push_back(m);

    // Advance: column first, then the order the direction gives
    wrapped = at_limit(col_pos, tw);
    col_pos = wrapped ? '0 : col_pos + 10'd1;
    if (reg_dir == DIR_TILE_TO_ROW) begin
      if (wrapped) begin
        wrapped = at_limit(row_pos, th);
        row_pos = wrapped ? '0 : row_pos + 10'd1;
      end
      if (wrapped) begin
        wrapped = at_limit(tile_x, ta);
        tile_x = wrapped ? '0 : tile_x + 4'd1;
      end
    end else begin
      if (wrapped) begin
        wrapped = at_limit(tile_x, ta);
        tile_x = wrapped ? '0 : tile_x + 4'd1;
      end
      if (wrapped) begin
        wrapped = at_limit(row_pos, th);
        row_pos = wrapped ? '0 : row_pos + 10'd1;
      end
    end
    if (wrapped) begin
      tile_y = at_limit(tile_y, td) ? '0 : tile_y + 4'd1;
    end
  endtask

  // Compare one output beat with the oldest mapped pixel
  task automatic check_beat();
    mapped_pixel_t m;
    beats_out++;
    if (mapped_q.size() == 0) begin
      $display("%0t: unexpected output beat, expected none, actual tdata %h tlast %b",
               $time, m_tdata, m_tlast);
      errors++;
    end else begin
      m = mapped_q.pop_front();
      if (m.last) atlas_ends++;
      if (m_tdata[DEST_W-1:0] !== m.dest) begin
        $display("%0t: dest_index expected %h actual %h", $time, m.dest,
                 m_tdata[DEST_W-1:0]);
        errors++;
      end
      if (m_tdata[DEST_W+PIX_W-1:DEST_W] !== m.pixel) begin
        $display("%0t: pixel_out expected %h actual %h", $time, m.pixel,
                 m_tdata[DEST_W+PIX_W-1:DEST_W]);
        errors++;
      end
      if (m_tdata[OUT_TDATA_W-1:DEST_W+PIX_W] !== '0) begin
        $display("%0t: tdata padding expected 0 actual %h", $time,
                 m_tdata[OUT_TDATA_W-1:DEST_W+PIX_W]);
        errors++;
      end
      if (m_tlast !== m.last) begin
        $display("%0t: last expected %b actual %b", $time, m.last, m_tlast);
        errors++;
      end
    end
  endtask

  // Drive pixel beats from the pending queue, with random gap bursts
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0 && src_gap_pct > 0 &&
                   $urandom_range(0, 99) < src_gap_pct) begin
        gap_left = $urandom_range(0, 3);
        s_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        next_pix = pixel_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_pix.pixel;
        s_tuser <= next_pix.restart;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Hold off the output side in random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Predict on each input beat, check each output beat
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        beats_in++;
        map_pixel(s_tdata, s_tuser);
      end
      if (m_tvalid && m_tready) check_beat();
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TILE_WIDTH:   reg_tile_w = val;
      REG_TILE_HEIGHT:  reg_tile_h = val;
      REG_TILES_ACROSS: reg_across = val[COUNT_REG_W-1:0];
      REG_TILES_DOWN:   reg_down = val[COUNT_REG_W-1:0];
      REG_DIRECTION:    reg_dir = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(input int tw, input int th, input int ta, input int td,
                           input logic dir);
    write_reg(REG_TILE_WIDTH, CFG_DATA_W'(tw));
    write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(th));
    write_reg(REG_TILES_ACROSS, CFG_DATA_W'(ta));
    write_reg(REG_TILES_DOWN, CFG_DATA_W'(td));
    write_reg(REG_DIRECTION, {CFG_DATA_W'($urandom_range(0, 1023)) << 1} | dir);
    end_writes();
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] pix, input logic restart);
    pixel_item_t it;
    it.pixel = pix;
    it.restart = restart;
    pixel_q.push_back(it);
    queued++;
  endtask

  // Wait until every pixel has gone through, then let the pipeline settle
  task automatic settle();
    while (pixel_q.size() != 0 || mapped_q.size() != 0 || s_tvalid ||
           beats_out < queued) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    phases++;
  endtask

  task automatic queue_random(input int n, input int first_restart_pct);
    for (int i = 0; i < n; i++) begin
      if (i == 0) queue_pixel($urandom, $urandom_range(0, 99) < first_restart_pct);
      else queue_pixel($urandom, $urandom_range(0, 99) < 2);
    end
    rand_pixels += n;
  endtask

  // Mostly small sizes, sometimes zero, the limit or above it
  function automatic logic [CFG_DATA_W-1:0] pick_size(input int top, input int reg_max);
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(top + 1, reg_max));
      2: return CFG_DATA_W'(top);
      3: return CFG_DATA_W'($urandom_range(1, top));
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_gap_pct = 30;
    sink_stall_pct = 30;

    // Reset defaults, extreme pixel values
    queue_pixel(32'h0000_0000, 1'b1);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    queue_pixel($urandom, 1'b0);
    queue_pixel($urandom, 1'b1);
    settle();

    // All size registers zero: every pixel is a whole atlas
    write_all(0, 0, 0, 0, DIR_TILE_TO_ROW);
    queue_pixel($urandom, 1'b0);
    queue_pixel($urandom, 1'b1);
    queue_pixel($urandom, 1'b0);
    settle();

    // Registers above their limits saturate
    write_all(2047, 1025, 31, 17, DIR_ROW_TO_TILE);
    queue_pixel($urandom, 1'b0);
    queue_pixel($urandom, 1'b1);
    queue_pixel($urandom, 1'b0);
    settle();

    // Small atlas run to its end and wrapped
    write_all(2, 1, 1, 2, DIR_TILE_TO_ROW);
    queue_pixel($urandom, 1'b1);
    for (int i = 0; i < 4; i++) queue_pixel($urandom, 1'b0);
    settle();

    // Flip direction mid-atlas, restart inside the run
    write_reg(REG_DIRECTION, CFG_DATA_W'(DIR_ROW_TO_TILE));
    end_writes();
    queue_pixel($urandom, 1'b0);
    queue_pixel($urandom, 1'b1);
    queue_pixel($urandom, 1'b0);
    settle();

    // Exact maximum sizes
    write_all(1024, 1024, 16, 16, DIR_TILE_TO_ROW);
    queue_pixel($urandom, 1'b1);
    queue_pixel($urandom, 1'b0);
    settle();

    // Walk the tile grid with one-pixel tiles, then blow the tiles up mid-atlas
    write_all(1, 1, 16, 16, 1'($urandom_range(0, 1)));
    queue_pixel($urandom, 1'b1);
    rand_pixels++;
    queue_random(249, 0);
    settle();
    write_reg(REG_TILE_WIDTH, CFG_DATA_W'(1024));
    write_reg(REG_TILE_HEIGHT, CFG_DATA_W'($urandom_range(1000, 2047)));
    end_writes();
    queue_random(20, 0);
    settle();

    // Random phases: random register subsets, counters kept across phases
    while (rand_pixels < RANDOM_PIXELS) begin
      if (RANDOM_PIXELS - rand_pixels <= CALM_TAIL) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end
      if ($urandom_range(0, 9) < 6) write_reg(REG_TILE_WIDTH, pick_size(1024, 2047));
      if ($urandom_range(0, 9) < 6) write_reg(REG_TILE_HEIGHT, pick_size(1024, 2047));
      if ($urandom_range(0, 9) < 6) write_reg(REG_TILES_ACROSS, pick_size(16, 31));
      if ($urandom_range(0, 9) < 6) write_reg(REG_TILES_DOWN, pick_size(16, 31));
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_DIRECTION, CFG_DATA_W'($urandom_range(0, 2047)));
      end_writes();
      n = $urandom_range(30, 120);
      if (n > RANDOM_PIXELS - rand_pixels) n = RANDOM_PIXELS - rand_pixels;
      queue_random(n, 40);
      settle();
    end

    $display("Sent %0d pixel beats, checked %0d output beats over %0d phases.",
             beats_in, beats_out, phases);
    $display("Saw %0d atlas ends across both directions and zero, saturated and mid-atlas"
             , atlas_ends);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

endmodule
